// ===== src/spct_pkg.sv =====
// Package: widths, pipeline record types and step functions for the collision-time core
`default_nettype none
package spct_pkg;

  localparam int W         = 32;
  localparam int F         = 16;
  localparam int EPS_RECIP = 1000000;
  localparam int QLIM      = ((1 << (F + 1)) - 1) / EPS_RECIP;
  localparam int LLIM      = ((1 << F) - 1) / EPS_RECIP;
  localparam int MW        = W + 1;
  localparam int CW        = W + 2;
  localparam int SW        = W + 2;
  localparam int DW        = 2 * SW;
  localparam int NW        = W + 3;
  localparam int HW        = (MW + 1) / 2;
  localparam int XW        = NW + F;

  typedef struct packed {
    logic          live;
    logic          quad;
    logic          cpos;
    logic          vneg;
    logic [MW-1:0] am;
    logic [MW-1:0] vm;
    logic [MW-1:0] cm;
  } cls_t;

  typedef struct packed {
    cls_t          c;
    logic [DW-1:0] d;
    logic [SW-1:0] root;
    logic [SW:0]   rem;
  } sq_t;

  typedef struct packed {
    logic          live;
    logic          sat;
    logic [MW-1:0] den;
    logic [MW-1:0] rem;
    logic [W-1:0]  nlo;
    logic [W-1:0]  q;
  } dv_t;

  function automatic sq_t sqrt_step(input sq_t s);
    sq_t           r;
    logic [SW+2:0] t;
    logic [SW+2:0] trial;
    r     = s;
    t     = {s.rem, s.d[DW-1:DW-2]};
    trial = {1'b0, s.root, 2'b01};
    if (t >= trial) begin
      r.rem  = (SW+1)'(t - trial);
      r.root = {s.root[SW-2:0], 1'b1};
    end else begin
      r.rem  = t[SW:0];
      r.root = {s.root[SW-2:0], 1'b0};
    end
    r.d = {s.d[DW-3:0], 2'b00};
    return r;
  endfunction

  function automatic dv_t div_step(input dv_t s);
    dv_t         r;
    logic [MW:0] t;
    r = s;
    t = {s.rem, s.nlo[W-1]};
    if (t >= {1'b0, s.den}) begin
      r.rem = MW'(t - {1'b0, s.den});
      r.q   = {s.q[W-2:0], 1'b1};
    end else begin
      r.rem = t[MW-1:0];
      r.q   = {s.q[W-2:0], 1'b0};
    end
    r.nlo = {s.nlo[W-2:0], 1'b0};
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/sphere_plane_collision_time_core.sv =====
// Top level: sphere against axis-aligned plane, first contact time under constant acceleration
// Throughput: one item per cycle; all stages advance together when the output is free.
// Square root takes W + 2 stages (two radicand bits each), division W stages (one quotient bit).
// Reset clears all stage valid bits; payload registers are not reset.
`default_nettype none
module sphere_plane_collision_time_core
  import spct_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic signed [W-1:0] pos_x,
  input  wire logic signed [W-1:0] pos_y,
  input  wire logic signed [W-1:0] pos_z,
  input  wire logic signed [W-1:0] vel_x,
  input  wire logic signed [W-1:0] vel_y,
  input  wire logic signed [W-1:0] vel_z,
  input  wire logic signed [W-1:0] acc_x,
  input  wire logic signed [W-1:0] acc_y,
  input  wire logic signed [W-1:0] acc_z,
  input  wire logic        [W-2:0] sphere_radius,
  input  wire logic        [2:0]   plane_code,
  input  wire logic signed [W-1:0] plane_offset,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     hit,
  output logic             [W-1:0] hit_time
);

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // stage 1: axis select and normal projection
  logic signed [W-1:0]  sel_p, sel_v, sel_a;
  logic signed [CW-1:0] dd;
  logic signed [MW-1:0] ve, ae;
  logic                 v1, r1_none;
  logic signed [CW-1:0] r1_c0;
  logic signed [MW-1:0] r1_v, r1_a;

  always_comb begin
    unique case (plane_code[2:1])
      2'd0:    begin sel_p = pos_x; sel_v = vel_x; sel_a = acc_x; end
      2'd1:    begin sel_p = pos_y; sel_v = vel_y; sel_a = acc_y; end
      2'd2:    begin sel_p = pos_z; sel_v = vel_z; sel_a = acc_z; end
      default: begin sel_p = '0;    sel_v = '0;    sel_a = '0;    end
    endcase
    dd = CW'(sel_p) - CW'(plane_offset);
    ve = MW'(sel_v);
    ae = MW'(sel_a);
    if (plane_code[0]) begin
      dd = -dd;
      ve = -ve;
      ae = -ae;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1_none <= (plane_code[2:1] == 2'd3);
      r1_c0   <= dd - $signed({3'b000, sphere_radius});
      r1_v    <= ve;
      r1_a    <= ae;
    end
  end

  // stage 2: classify, normalize sign of the quadratic term, magnitudes
  logic [MW-1:0]        am_c;
  logic                 quad_c, flip;
  logic signed [CW-1:0] c0n;
  logic signed [MW-1:0] vn;
  logic                 cneg, czero;
  cls_t                 cls_c;
  logic                 v2, v3, v4;
  cls_t                 r2, r3, r4;

  always_comb begin
    am_c   = r1_a[MW-1] ? MW'(-r1_a) : MW'(r1_a);
    quad_c = am_c > MW'(QLIM);
    flip   = quad_c && r1_a[MW-1];
    c0n    = flip ? -r1_c0 : r1_c0;
    vn     = flip ? -r1_v : r1_v;
    cneg   = c0n[CW-1];
    czero  = (c0n == '0);
    cls_c.quad = quad_c;
    cls_c.am   = am_c;
    cls_c.vm   = vn[MW-1] ? MW'(-vn) : MW'(vn);
    cls_c.cm   = cneg ? MW'(-c0n) : MW'(c0n);
    cls_c.vneg = vn[MW-1];
    cls_c.cpos = !cneg && !czero;
    if (quad_c) begin
      cls_c.live = !r1_none && (vn[MW-1] || cneg);
    end else begin
      cls_c.live = !r1_none && (cls_c.vm > MW'(LLIM)) && !czero && (cneg != vn[MW-1]);
    end
  end

  // stage 3: partial products; stage 4: sums
  logic [MW+HW-1:0] vv_lo, ac_lo;
  logic [2*MW-HW-1:0] vv_hi, ac_hi;
  logic [DW-1:0]    sq, pp;

  always_ff @(posedge clk) begin
    if (adv) begin
      r2    <= cls_c;
      r3    <= r2;
      vv_lo <= (MW+HW)'(r2.vm) * (MW+HW)'(r2.vm[HW-1:0]);
      vv_hi <= (2*MW-HW)'(r2.vm) * (2*MW-HW)'(r2.vm[MW-1:HW]);
      ac_lo <= (MW+HW)'(r2.cm) * (MW+HW)'(r2.am[HW-1:0]);
      ac_hi <= (2*MW-HW)'(r2.cm) * (2*MW-HW)'(r2.am[MW-1:HW]);
      r4    <= r3;
      sq    <= DW'(vv_lo) + (DW'(vv_hi) << HW);
      pp    <= (DW'(ac_lo) + (DW'(ac_hi) << HW)) << 1;
    end
  end

  // stage 5: discriminant, then square root stages
  sq_t  seed;
  sq_t  sqp [0:SW];
  logic sqv [0:SW];

  always_comb begin
    seed.c    = r4;
    seed.root = '0;
    seed.rem  = '0;
    seed.d    = r4.cpos ? sq - pp : sq + pp;
    if (r4.quad && r4.cpos && (sq < pp)) begin
      seed.c.live = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqp[0] <= seed;
      for (int k = 1; k <= SW; k++) begin
        sqp[k] <= sqrt_step(sqp[k-1]);
      end
    end
  end

  // numerator and divisor select
  logic [NW-1:0] num_c;
  logic [NW-1:0] s_e, vm_e;
  logic          v6, r6_live;
  logic [NW-1:0] r6_num;
  logic [MW-1:0] r6_den;

  always_comb begin
    s_e  = NW'(sqp[SW].root);
    vm_e = NW'(sqp[SW].c.vm);
    if (!sqp[SW].c.quad) begin
      num_c = NW'(sqp[SW].c.cm);
    end else if (sqp[SW].c.vneg) begin
      num_c = sqp[SW].c.cpos ? vm_e - s_e : vm_e + s_e;
    end else begin
      num_c = s_e - vm_e;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r6_live <= sqp[SW].c.live;
      r6_num  <= num_c;
      r6_den  <= sqp[SW].c.quad ? sqp[SW].c.am : sqp[SW].c.vm;
    end
  end

  // saturation check and divider seed, then divider stages
  logic [XW-1:0] nsh, nhi;
  dv_t           dseed;
  dv_t           dvp [0:W];
  logic          dvv [0:W];

  always_comb begin
    nsh        = {r6_num, {F{1'b0}}};
    nhi        = nsh >> W;
    dseed.live = r6_live;
    dseed.sat  = nhi >= XW'(r6_den);
    dseed.den  = r6_den;
    dseed.rem  = nhi[MW-1:0];
    dseed.nlo  = nsh[W-1:0];
    dseed.q    = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dvp[0] <= dseed;
      for (int k = 1; k <= W; k++) begin
        dvp[k] <= div_step(dvp[k-1]);
      end
      hit      <= dvp[W].live;
      hit_time <= !dvp[W].live ? '0 : (dvp[W].sat ? '1 : dvp[W].q);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v6        <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k <= SW; k++) sqv[k] <= 1'b0;
      for (int k = 0; k <= W; k++) dvv[k] <= 1'b0;
    end else if (adv) begin
      v1     <= in_valid;
      v2     <= v1;
      v3     <= v2;
      v4     <= v3;
      sqv[0] <= v4;
      for (int k = 1; k <= SW; k++) sqv[k] <= sqv[k-1];
      v6     <= sqv[SW];
      dvv[0] <= v6;
      for (int k = 1; k <= W; k++) dvv[k] <= dvv[k-1];
      out_valid <= dvv[W];
    end
  end

  a_nohit_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> hit_time == '0)
    else $error("no-hit result with nonzero time");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire
